FILE: rtl/core/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and constants for the Laplace inversion sampler.
// ----------------------------------------------------------------------------
package lis_pkg;

	localparam int FRAC_BITS = 24;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	typedef enum logic [2:0] {
		REG_WINDOW_LOW  = 3'd0,
		REG_WINDOW_HIGH = 3'd1,
		REG_LOCATION    = 3'd2,
		REG_SCALE       = 3'd3,
		REG_APPLY_LS    = 3'd4
	} reg_idx_t;

	// Sideband that travels with each item down the chain
	typedef struct packed {
		logic       valid;
		logic       inf;
		logic       neg;
		logic [4:0] shift;
	} sb_t;

endpackage

FILE: rtl/core/lis_front.sv
// ----------------------------------------------------------------------------
// lis_front
// Maps the sample into the window, folds it around one half and normalizes
// the mantissa for the log chain. Three stages.
// ----------------------------------------------------------------------------
module lis_front import lis_pkg::*; #(
	parameter int UNIFORM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] sample,
	input  logic [32:0] window_low,
	input  logic [32:0] window_high,
	output sb_t         sb,
	output logic [31:0] z
);

	localparam logic [63:0] UMASK = (64'd1 << UNIFORM_BITS) - 64'd1;

	logic        fwd;
	logic [32:0] span;
	logic [31:0] u;
	logic        valid_s1, fwd_s1;
	logic [64:0] prod_s1;
	logic [32:0] low_s1;
	logic [64:0] prod_shr;
	logic [32:0] off;
	logic [33:0] w;
	logic        valid_s2, inf_s2, neg_s2;
	logic [31:0] v_s2;
	logic [4:0]  top;
	logic [4:0]  shift;
	logic        valid_s3, inf_s3, neg_s3;
	logic [4:0]  shift_s3;
	logic [31:0] z_s3;

	assign fwd  = window_high >= window_low;
	assign span = fwd ? window_high - window_low : window_low - window_high;
	assign u    = sample & UMASK[31:0];

	// Scale the sample across the window span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {33'd0, u} * {32'd0, span};
			low_s1  <= window_low;
			fwd_s1  <= fwd;
		end
	end

	// Offset from the low bound and fold to the lower half
	assign prod_shr = prod_s1 >> UNIFORM_BITS;
	assign off      = prod_shr[32:0];
	assign w        = fwd_s1 ? {1'b0, low_s1} + {1'b0, off} : {1'b0, low_s1} - {1'b0, off};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			// drop a zero draw
			valid_s2 <= valid_s1 && (w != 34'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inf_s2 <= w[33:32] != 2'd0;
			neg_s2 <= w <= 34'h080000000;
			v_s2   <= (w <= 34'h080000000) ? w[31:0] : 32'(34'h100000000 - w);
		end
	end

	// Normalize: find the top set bit
	always_comb begin
		top = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v_s2[i]) begin
				top = 5'(i);
			end
		end
	end
	assign shift = 5'd31 - top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inf_s3   <= inf_s2;
			neg_s3   <= neg_s2;
			shift_s3 <= shift;
			z_s3     <= v_s2 << shift;
		end
	end

	assign sb = '{valid: valid_s3, inf: inf_s3, neg: neg_s3, shift: shift_s3};
	assign z  = z_s3;

endmodule

FILE: rtl/core/lis_cell.sv
// ----------------------------------------------------------------------------
// lis_cell
// One step of the log2 chain: square the mantissa and emit one fraction bit.
// ----------------------------------------------------------------------------
module lis_cell import lis_pkg::*; #(
	parameter int BIT_POS = 23
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  sb_t                  sb_in,
	input  logic [31:0]          z_in,
	input  logic [FRAC_BITS-1:0] frac_in,
	output sb_t                  sb_out,
	output logic [31:0]          z_out,
	output logic [FRAC_BITS-1:0] frac_out
);

	logic [63:0] sq;
	logic [32:0] t;
	logic        valid_q;
	logic        inf_q;
	logic        neg_q;
	logic [4:0]  shift_q;
	logic [31:0] z_q;
	logic [FRAC_BITS-1:0] frac_d;
	logic [FRAC_BITS-1:0] frac_q;

	assign sq = {32'd0, z_in} * {32'd0, z_in};
	assign t  = sq[63:31];

	// Insert this cell's fraction bit
	always_comb begin
		frac_d          = frac_in;
		frac_d[BIT_POS] = t[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= sb_in.valid;
		end
	end

	// Renormalize when the square reaches two
	always_ff @(posedge clk) begin
		if (en) begin
			inf_q   <= sb_in.inf;
			neg_q   <= sb_in.neg;
			shift_q <= sb_in.shift;
			z_q     <= t[32] ? t[32:1] : t[31:0];
			frac_q  <= frac_d;
		end
	end

	assign sb_out   = '{valid: valid_q, inf: inf_q, neg: neg_q, shift: shift_q};
	assign z_out    = z_q;
	assign frac_out = frac_q;

endmodule

FILE: rtl/core/lis_back.sv
// ----------------------------------------------------------------------------
// lis_back
// Converts log2 to ln, applies mode, location and scale, and saturates.
// ----------------------------------------------------------------------------
module lis_back import lis_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  sb_t                  sb,
	input  logic [FRAC_BITS-1:0] frac,
	input  logic signed [31:0]   location,
	input  logic [30:0]          scale,
	input  logic                 apply_ls,
	output logic                 res_valid,
	output logic [31:0]          res_variate,
	output logic                 res_sat
);

	logic [28:0] l2;
	logic        valid_b1, inf_b1, neg_b1;
	logic [60:0] lnp_b1;
	logic [61:0] lnr;
	logic [28:0] mag;
	logic        valid_b2, inf_b2, neg_b2;
	logic [59:0] sp_b2;
	logic [20:0] m16_b2;
	logic [59:0] spr;
	logic [35:0] m;
	logic signed [37:0] val;
	logic        valid_b3, sat_b3;
	logic [31:0] var_b3;

	assign l2 = {sb.shift, 24'd0} - {5'd0, frac};

	// Multiply by ln 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			valid_b2 <= 1'b0;
			valid_b3 <= 1'b0;
		end else if (en) begin
			valid_b1 <= sb.valid;
			valid_b2 <= valid_b1;
			valid_b3 <= valid_b2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lnp_b1 <= {32'd0, l2} * {29'd0, LN2_Q32};
			inf_b1 <= sb.inf;
			neg_b1 <= sb.neg;
		end
	end

	// Round ln magnitude, then scale
	assign lnr = {1'b0, lnp_b1} + 62'h080000000;
	assign mag = lnr[60:32];

	always_ff @(posedge clk) begin
		if (en) begin
			sp_b2  <= {29'd0, scale} * {31'd0, mag};
			m16_b2 <= 21'(({1'b0, mag} + 30'd128) >> 8);
			inf_b2 <= inf_b1;
			neg_b2 <= neg_b1;
		end
	end

	// Apply location in location/scale mode, and saturate
	assign spr = sp_b2 + 60'h800000;
	assign m   = spr[59:24];

	always_comb begin
		if (apply_ls) begin
			val = 38'(location) + (neg_b2 ? -$signed({2'b0, m}) : $signed({2'b0, m}));
		end else begin
			val = neg_b2 ? -$signed({17'd0, m16_b2}) : $signed({17'd0, m16_b2});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (inf_b2 || val > 38'sh7FFFFFFF) begin
				var_b3 <= 32'h7FFFFFFF;
				sat_b3 <= 1'b1;
			end else if (val < -38'sh80000000) begin
				var_b3 <= 32'h80000000;
				sat_b3 <= 1'b1;
			end else begin
				var_b3 <= val[31:0];
				sat_b3 <= 1'b0;
			end
		end
	end

	assign res_valid   = valid_b3;
	assign res_variate = var_b3;
	assign res_sat     = sat_b3;

endmodule

FILE: rtl/core/laplace_inversion_sampler.sv
// ----------------------------------------------------------------------------
// laplace_inversion_sampler
// Laplace variates by inversion: window, fold, 24-cell log2 chain, ln/scale.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in       | input     | in_valid/in_stall  | uniform_sample
//  out      | output    | out_valid/out_stall| variate, saturated
//  cfg      | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while no result is stalled; the path is 3 front stages, 24
// squaring cells, 3 back stages and the output register.
// A zero draw produces no result. Reset clears all valid bits and loads the
// register defaults. An out_stall while a result is held freezes the whole chain,
// and in_stall follows it in the same cycle.
// ----------------------------------------------------------------------------
module laplace_inversion_sampler import lis_pkg::*; #(
	parameter int UNIFORM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] uniform_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] variate,
	output logic        saturated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [32:0] cfg_data
);

	logic [32:0] window_low_q, window_high_q;
	logic signed [31:0] location_q;
	logic [30:0] scale_q;
	logic        apply_ls_q;
	logic        en;
	sb_t         sb_c [25];
	logic [31:0] z_c [25];
	logic [FRAC_BITS-1:0] frac_c [25];
	logic        res_valid, res_sat;
	logic [31:0] res_variate;
	logic        out_valid_q, sat_q;
	logic [31:0] variate_q;

	// Advance unless a result is held
	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= 33'd0;
			window_high_q <= 33'h100000000;
			location_q    <= 32'sd0;
			scale_q       <= 31'd65536;
			apply_ls_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WINDOW_LOW:  window_low_q  <= cfg_data;
				REG_WINDOW_HIGH: window_high_q <= cfg_data;
				REG_LOCATION:    location_q    <= cfg_data[31:0];
				REG_SCALE:       scale_q       <= cfg_data[30:0];
				REG_APPLY_LS:    apply_ls_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lis_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid), .sample(uniform_sample),
		.window_low(window_low_q), .window_high(window_high_q),
		.sb(sb_c[0]), .z(z_c[0])
	);
	assign frac_c[0] = '0;

	// Chain of squaring cells, most significant fraction bit first
	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
		lis_cell #(.BIT_POS(FRAC_BITS - 1 - i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.sb_in(sb_c[i]), .z_in(z_c[i]), .frac_in(frac_c[i]),
			.sb_out(sb_c[i+1]), .z_out(z_c[i+1]), .frac_out(frac_c[i+1])
		);
	end

	lis_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.sb(sb_c[FRAC_BITS]), .frac(frac_c[FRAC_BITS]),
		.location(location_q), .scale(scale_q), .apply_ls(apply_ls_q),
		.res_valid(res_valid), .res_variate(res_variate), .res_sat(res_sat)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			variate_q <= res_variate;
			sat_q     <= res_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign variate   = variate_q;
	assign saturated = sat_q;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Laplace inversion sampler: a queue-fed driver,
// a monitor that checks each result against a bit-exact software predictor,
// register settings swept between phases under varied idle and stall load.
// ----------------------------------------------------------------------------
module tb_top;
	import lis_pkg::*;

	typedef struct {
		logic [31:0] variate;
		logic        saturated;
	} variate_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] uniform_sample;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] variate;
	logic        saturated;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [32:0] cfg_data;

	// predictor copy of the registers
	logic [32:0] win_lo;
	logic [32:0] win_hi;
	logic signed [31:0] loc_q;
	logic [30:0] scale_q;
	logic        ls_mode;

	logic [31:0] sample_q[$];
	variate_t    expected_q[$];
	int          send_idle;
	int          recv_stall;
	int          errors;
	logic        in_taken;

	laplace_inversion_sampler DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .uniform_sample(uniform_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.variate(variate), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// |ln(v / 2^31)| in Q8.24 by repeated squaring of the mantissa
	function automatic logic [63:0] ln_mag(input logic [63:0] v);
		int          k;
		logic [63:0] z;
		logic [63:0] frac;
		logic [63:0] l2;
		logic [127:0] p;
		k = 31;
		frac = 0;
		while (k > 0 && v[k] == 1'b0)
			k--;
		z = v << (31 - k);
		for (int i = 1; i <= 24; i++) begin
			z = (z * z) >> 31;
			if (z >= 64'h1_0000_0000) begin
				z = z >> 1;
				frac[24 - i] = 1'b1;
			end
		end
		l2 = (64'(31 - k) << 24) - frac;
		p = 128'(l2) * 128'(LN2_Q32) + 128'h8000_0000;
		return 64'(p >> 32);
	endfunction

	// predict the result of one sample; returns 0 when the draw is dropped
	function automatic bit predict_variate(input logic [31:0] u, output variate_t r);
		logic [63:0]  w;
		logic [63:0]  v;
		logic [63:0]  mag;
		logic [63:0]  m16;
		logic [127:0] span;
		logic signed [63:0] val;
		bit           neg;
		if (win_hi >= win_lo) begin
			span = 128'(u) * 128'(win_hi - win_lo);
			w = 64'(win_lo) + 64'(span >> 32);
		end else begin
			span = 128'(u) * 128'(win_lo - win_hi);
			w = 64'(win_lo) - 64'(span >> 32);
		end
		if (w == 0)
			return 0;
		r.saturated = 1'b0;
		if (w >= 64'h1_0000_0000) begin
			r.variate = 32'h7FFF_FFFF;
			r.saturated = 1'b1;
			return 1;
		end
		neg = (w <= 64'h8000_0000);
		v = neg ? w : 64'h1_0000_0000 - w;
		mag = ln_mag(v);
		if (!ls_mode) begin
			m16 = (mag + 128) >> 8;
			val = neg ? -$signed(m16) : $signed(m16);
		end else begin
			m16 = (64'(scale_q) * mag + 64'h80_0000) >> 24;
			val = 64'(loc_q) + (neg ? -$signed(m16) : $signed(m16));
		end
		if (val > 64'sh7FFF_FFFF) begin
			val = 64'sh7FFF_FFFF;
			r.saturated = 1'b1;
		end else if (val < -64'sh8000_0000) begin
			val = -64'sh8000_0000;
			r.saturated = 1'b1;
		end
		r.variate = val[31:0];
		return 1;
	endfunction

	// driver: offer the next pending item, with random idle cycles
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					uniform_sample <= sample_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	// predict at acceptance so the current register copy applies
	always @(posedge clk) begin
		variate_t r;
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall && predict_variate(uniform_sample, r))
			expected_q.push_back(r);
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		variate_t e;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result: variate %h sat %b", $time, variate, saturated);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (e.variate !== variate || e.saturated !== saturated) begin
					$display("%0t mismatch: expected %h/%b actual %h/%b",
						$time, e.variate, e.saturated, variate, saturated);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [32:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WINDOW_LOW:  win_lo = data;
			REG_WINDOW_HIGH: win_hi = data;
			REG_LOCATION:    loc_q = data[31:0];
			REG_SCALE:       scale_q = data[30:0];
			REG_APPLY_LS:    ls_mode = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for the pipe to drain, then for dropped items still in flight
	task automatic drain();
		while (sample_q.size() > 0 || in_valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(5))
			0: return $urandom_range(15);
			1: return 32'hFFFF_FFFF - $urandom_range(15);
			2: return 32'h8000_0000 + $urandom_range(31) - 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [32:0] rand_window();
		case ($urandom_range(4))
			0: return 33'h0;
			1: return 33'h1_0000_0000;
			2: return 33'h1_0000_0000 + 33'($urandom_range(7));
			3: return {1'($urandom_range(1)), 32'($urandom)};
			default: return {1'b0, 32'($urandom)};
		endcase
	endfunction

	initial begin
		errors = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_taken = 1'b0;
		uniform_sample = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_WINDOW_LOW;
		cfg_data = '0;
		send_idle = 0;
		recv_stall = 0;
		win_lo = 0;
		win_hi = 33'h1_0000_0000;
		loc_q = 0;
		scale_q = 31'd65536;
		ls_mode = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero draw, fold point, extremes, at default registers
		sample_q = {32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
			32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h4000_0000, 32'hC000_0000,
			32'hAAAA_AAAA, 32'h5555_5555};
		drain();
		// reversed window and infinite variate, then full-scale location/scale
		write_reg(REG_WINDOW_LOW, 33'h1_FFFF_FFFF);
		write_reg(REG_WINDOW_HIGH, 33'h0);
		sample_q = {32'h0, 32'h1, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000};
		drain();
		write_reg(REG_WINDOW_LOW, 33'h0);
		write_reg(REG_WINDOW_HIGH, 33'h1_0000_0000);
		write_reg(REG_APPLY_LS, 33'd1);
		write_reg(REG_SCALE, 33'h0_7FFF_FFFF);
		write_reg(REG_LOCATION, 33'h0_8000_0000);
		sample_q = {32'h1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0010};
		drain();
		write_reg(REG_LOCATION, 33'h0_7FFF_FFFF);
		write_reg(REG_SCALE, 33'h0);
		sample_q = {32'h1, 32'hFFFF_FFFF};
		drain();

		// random phases under each load profile and a fresh register setting
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 49; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 49; end
				default: begin send_idle = 10; recv_stall = 10; end
			endcase
			write_reg(REG_APPLY_LS, 33'($urandom_range(1)));
			write_reg(REG_SCALE, {2'b0, ($urandom_range(1) ? 31'($urandom) :
				31'($urandom_range(262144)))});
			write_reg(REG_LOCATION, {1'b0, 32'($urandom)});
			if ($urandom_range(2) == 0) begin
				write_reg(REG_WINDOW_LOW, rand_window());
				write_reg(REG_WINDOW_HIGH, rand_window());
			end else begin
				write_reg(REG_WINDOW_LOW, 33'h0);
				write_reg(REG_WINDOW_HIGH, 33'h1_0000_0000);
			end
			write_reg(reg_idx_t'(3'd5 + 3'($urandom_range(2))), 33'($urandom));
			for (int n = 0; n < 114; n++)
				sample_q.push_back(rand_sample());
			drain();
		end

		if (errors == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: laplace_inversion_sampler.f
rtl/core/lis_pkg.sv
rtl/core/lis_front.sv
rtl/core/lis_cell.sv
rtl/core/lis_back.sv
rtl/core/laplace_inversion_sampler.sv
bench/tb_top.sv
